FILE: hw/rtl/pts_pkg.sv
// Package: shared constants, controller state type and command/status structs for the packetizer.
package pts_pkg;

  localparam int unsigned PAYLOAD_BYTES = 184;
  localparam int unsigned PKT_BYTES     = 188;
  localparam int unsigned PID_W         = 13;
  localparam int unsigned FILL_W        = $clog2(PAYLOAD_BYTES);
  localparam int unsigned POS_W         = $clog2(PKT_BYTES + 1);

  localparam logic [7:0] TS_SYNC       = 8'h47;
  localparam logic [7:0] STUFF_BYTE    = 8'hff;
  localparam logic [7:0] AF_FLAG_DISC  = 8'h80;
  localparam logic [7:0] AF_FLAG_NONE  = 8'h00;

  // header byte positions and the adaptation field
  localparam logic [POS_W-1:0] POS_SYNC   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_PID_HI = POS_W'(1);
  localparam logic [POS_W-1:0] POS_PID_LO = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CTRL   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_AF_LEN = POS_W'(4);
  localparam logic [POS_W-1:0] POS_AF_FLG = POS_W'(5);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ASM,
    ST_SEND
  } ctl_state_e;

  typedef struct packed {
    logic accept;    // input byte transfer this cycle
    logic asm_byte;  // shift one packet byte into the word register
  } ctl_cmd_t;

  typedef struct packed {
    logic pkt_due;   // accepted byte closes a packet
    logic word_done; // byte being assembled is the fourth of a word
    logic pkt_done;  // word on the output is the last of the packet
  } dp_status_t;

endpackage

FILE: hw/rtl/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 184
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/pts_ctrl.sv
// Controller FSM: input acceptance, byte fetch/assemble sequencing, word output handshake.
module pts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  pts_pkg::dp_status_t status_i,
  output pts_pkg::ctl_cmd_t   cmd_o
);

  pts_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.pkt_due) begin
          state_d = pts_pkg::ST_FETCH;
        end
      end
      pts_pkg::ST_FETCH: begin
        state_d = pts_pkg::ST_ASM;
      end
      pts_pkg::ST_ASM: begin
        state_d = status_i.word_done ? pts_pkg::ST_SEND : pts_pkg::ST_FETCH;
      end
      pts_pkg::ST_SEND: begin
        if (!out_stall_i) begin
          state_d = status_i.pkt_done ? pts_pkg::ST_IDLE : pts_pkg::ST_FETCH;
        end
      end
      default: state_d = pts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = 1'b1;
    out_valid_o    = 1'b0;
    cmd_o.accept   = 1'b0;
    cmd_o.asm_byte = 1'b0;
    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      pts_pkg::ST_FETCH: ;
      pts_pkg::ST_ASM: begin
        cmd_o.asm_byte = 1'b1;
      end
      pts_pkg::ST_SEND: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  // input and output never transfer in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("input open while a word is offered");

  // a packet start always leads into a fetch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && status_i.pkt_due) |=> state_q == pts_pkg::ST_FETCH)
    else $error("packet start did not begin fetching");

  // a word is offered only right after its fourth byte or while held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd_o.asm_byte) && $past(status_i.word_done))
    else $error("word offered before it was complete");

endmodule

FILE: hw/rtl/pts_datapath.sv
// Datapath: payload store, packet header state and byte-serial word assembly.
module pts_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pts_pkg::ctl_cmd_t             cmd_i,
  output pts_pkg::dp_status_t           status_o,
  input  logic [pts_pkg::PID_W-1:0]     pid_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          pes_end_i,
  input  logic                          mark_discontinuity_i,
  output logic [31:0]                   packet_word_o,
  output logic                          packet_last_o
);

  localparam logic [pts_pkg::FILL_W-1:0] FillLast = pts_pkg::FILL_W'(pts_pkg::PAYLOAD_BYTES - 1);
  localparam logic [pts_pkg::FILL_W:0]   NFull    = (pts_pkg::FILL_W+1)'(pts_pkg::PAYLOAD_BYTES);
  localparam logic [pts_pkg::POS_W:0]    PktLen   = (pts_pkg::POS_W+1)'(pts_pkg::PKT_BYTES);

  // running state
  logic [pts_pkg::FILL_W-1:0] fill_q, fill_d;
  logic                       start_q, start_d;
  logic [3:0]                 cc_q, cc_d;
  logic                       disc_q, disc_d;

  // per-packet captured fields
  logic [pts_pkg::FILL_W:0]   n_q;
  logic                       pusi_q;
  logic [3:0]                 pkt_cc_q;
  logic                       flag_q;

  logic [pts_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [31:0]                word_q;

  logic                       start_pkt;
  logic                       disc_now;
  logic                       use_flag;
  logic [pts_pkg::FILL_W:0]   n_new;
  logic [pts_pkg::POS_W:0]    pos_plus_n;
  logic [pts_pkg::FILL_W-1:0] raddr;
  logic [7:0]                 rdata;
  logic [7:0]                 pkt_byte;
  logic                       adapt;
  logic [pts_pkg::FILL_W:0]   af_len;

  assign n_new     = {1'b0, fill_q} + 1'b1;
  assign start_pkt = cmd_i.accept && status_o.pkt_due;
  assign disc_now  = disc_q | mark_discontinuity_i;
  // discontinuity flag fits only when the adaptation field has two or more bytes
  assign use_flag  = disc_now && (n_new < NFull - 1'b1);

  assign status_o.pkt_due   = pes_end_i || (fill_q == FillLast);
  assign status_o.word_done = pos_q[1:0] == 2'b11;
  assign status_o.pkt_done  = {1'b0, pos_q} == PktLen;

  always_comb begin
    fill_d  = fill_q;
    start_d = start_q;
    cc_d    = cc_q;
    disc_d  = disc_q;
    if (cmd_i.accept) begin
      disc_d = disc_now;
      fill_d = n_new[pts_pkg::FILL_W-1:0];
      if (status_o.pkt_due) begin
        fill_d  = '0;
        start_d = pes_end_i;
        cc_d    = cc_q + 4'd1;
        disc_d  = disc_now & ~use_flag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      start_q <= 1'b1;
      cc_q    <= '0;
      disc_q  <= 1'b0;
      pos_q   <= '0;
    end else begin
      fill_q  <= fill_d;
      start_q <= start_d;
      cc_q    <= cc_d;
      disc_q  <= disc_d;
      pos_q   <= pos_d;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (start_pkt) begin
      pos_d = '0;
    end else if (cmd_i.asm_byte) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_pkt) begin
      n_q      <= n_new;
      pusi_q   <= start_q;
      pkt_cc_q <= cc_q;
      flag_q   <= use_flag;
    end
    if (cmd_i.asm_byte) begin
      word_q <= {word_q[23:0], pkt_byte};
    end
  end

  // payload byte i sits at packet position 188 - n + i
  assign pos_plus_n = {1'b0, pos_q} + (pts_pkg::POS_W+1)'(n_q);
  assign raddr      = pts_pkg::FILL_W'(pos_plus_n - PktLen);

  pts_ram #(
    .WIDTH (8),
    .DEPTH (pts_pkg::PAYLOAD_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (fill_q),
    .wdata_i (data_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign adapt  = n_q < NFull;
  assign af_len = NFull - n_q - 1'b1;

  always_comb begin
    if (pos_plus_n >= PktLen) begin
      pkt_byte = rdata;
    end else begin
      case (pos_q)
        pts_pkg::POS_SYNC:   pkt_byte = pts_pkg::TS_SYNC;
        pts_pkg::POS_PID_HI: pkt_byte = {1'b0, pusi_q, 1'b0, pid_i[12:8]};
        pts_pkg::POS_PID_LO: pkt_byte = pid_i[7:0];
        pts_pkg::POS_CTRL:   pkt_byte = {2'b00, adapt, 1'b1, pkt_cc_q};
        pts_pkg::POS_AF_LEN: pkt_byte = af_len[7:0];
        pts_pkg::POS_AF_FLG: pkt_byte = flag_q ? pts_pkg::AF_FLAG_DISC : pts_pkg::AF_FLAG_NONE;
        default:             pkt_byte = pts_pkg::STUFF_BYTE;
      endcase
    end
  end

  assign packet_word_o = word_q;
  assign packet_last_o = status_o.pkt_done;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fill_q} < NFull)
    else $error("fill count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} <= PktLen)
    else $error("byte position past packet end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_pkt |=> fill_q == '0 && pos_q == '0)
    else $error("packet start did not clear fill and position");

endmodule

FILE: hw/rtl/pes_to_ts_packetizer_top.sv
// Top level: PES byte stream in, 188-byte transport packets out as 47 words.
// Input: one byte per cycle while collecting; the byte that fills 184 bytes or ends
// a PES starts a packet and closes the input until its 47 words have left.
// Packet output: each word is built by fetching and assembling four bytes
// through the one store read port, then offered and held while out_stall_i is high.
// First word is offered once its four bytes are fetched and assembled after the closing byte.
// Reset (rst_ni low, async): empty store, PES start set, continuity 0, no pending
// discontinuity, PID 0. Store contents are not cleared; only written bytes are read.
module pes_to_ts_packetizer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // PID configuration write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pts_pkg::PID_W-1:0] cfg_pid_i,
  // PES byte input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      pes_end_i,
  input  logic                      mark_discontinuity_i,
  // transport packet word output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [31:0]               packet_word_o,
  output logic                      packet_last_o
);

  pts_pkg::ctl_cmd_t   cmd;
  pts_pkg::dp_status_t status;
  logic [pts_pkg::PID_W-1:0] pid_q;

  // PID register: writes are always taken; the user must change config only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q <= '0;
    end else if (cfg_valid_i) begin
      pid_q <= cfg_pid_i;
    end
  end

  // sequencing: accept, fetch/assemble per byte, send per word
  pts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // payload store, header fields and word builder
  pts_datapath u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .pid_i                (pid_q),
    .data_byte_i          (data_byte_i),
    .pes_end_i            (pes_end_i),
    .mark_discontinuity_i (mark_discontinuity_i),
    .packet_word_o        (packet_word_o),
    .packet_last_o        (packet_last_o)
  );

endmodule
